FILE: hdl/nearest_neighbor_distance_core_macros.svh
// Assertion macros shared by the nearest neighbor distance core.
`ifndef NEAREST_NEIGHBOR_DISTANCE_CORE_MACROS_SVH
`define NEAREST_NEIGHBOR_DISTANCE_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define NND_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nnd assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define NND_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nnd assertion failed");
`else
`define NND_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define NND_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/nnd_pkg.sv
// Shared types and constants for the nearest neighbor distance core.
`timescale 1ns / 1ps

package nnd_pkg;

    // Fixed field widths
    localparam int INDEX_W    = 10;
    localparam int COUNT_W    = 11;
    localparam int SEP_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SEP_W;

    // Item operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEP     = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load_we;
        logic q_start;
        logic q_latch;
        logic walk_issue;
        logic sqrt_start;
        logic result_load;
    } nnd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic q_oob;
        logic walk_done;
        logic pipe_empty;
        logic found;
        logic sqrt_done;
    } nnd_stat_t;

endpackage

FILE: hdl/nearest_neighbor_distance_core.sv
// Load item: written into the store at the accepting edge; in_ready stays high.
// Query item: walks min(point_count, MAX_POINTS) slots, one point per cycle, through a
// 4-stage distance pipe, then takes the square root of the minimum, one root bit per cycle.
// A finished result waits in the output register; items are taken meanwhile.
// Reset clears control state and sets point_count 0, max_separation 131071.
// The point store is not cleared; slots read before any load hold undefined data.
`timescale 1ns / 1ps

module nearest_neighbor_distance_core
    import nnd_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  logic [INDEX_W-1:0]           index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [SEP_W-1:0]             min_distance,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

    nnd_cmd_t  cmd;
    nnd_stat_t stat;

    // Sequencer
    nnd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .op        (op),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Store and arithmetic
    nnd_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .index        (index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .min_distance (min_distance)
    );

endmodule

FILE: hdl/nnd_isqrt.sv
// Iterative floor square root, one result bit per cycle.
`timescale 1ns / 1ps

module nnd_isqrt #(
    parameter int IN_W = 36
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [IN_W-1:0]         value,
    output logic                    busy,
    output logic                    done,
    output logic [(IN_W+1)/2-1:0]   root
);

    localparam int RW    = (IN_W + 1) / 2;
    localparam int N2    = 2 * RW;
    localparam int REM_W = RW + 3;
    localparam int CNT_W = $clog2(RW + 1);

    logic [N2-1:0]    v_reg;
    logic [REM_W-1:0] rem_reg;
    logic [RW-1:0]    root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    // Bring down the next bit pair and try the next root bit
    assign rem_sh = {rem_reg[REM_W-3:0], v_reg[N2-1 -: 2]};
    assign trial  = REM_W'({root_reg, 2'b01});
    assign fits   = rem_sh >= trial;

    // Control: busy and done flags, iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(RW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Data: operand shifter, remainder, partial root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= N2'(value);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg <= {v_reg[N2-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

FILE: hdl/nnd_dp.sv
// Datapath: point store, distance pipeline, running minimum, square root, result.
`timescale 1ns / 1ps
`include "nearest_neighbor_distance_core_macros.svh"

module nnd_dp
    import nnd_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nnd_cmd_t                    cmd,
    output nnd_stat_t                   stat,
    input  logic [INDEX_W-1:0]          index,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    output logic [SEP_W-1:0]            min_distance
);

    localparam int CB    = COORD_BITS;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int LIM_W = AW + 1;
    localparam int LW2   = (COUNT_W > LIM_W) ? COUNT_W : LIM_W;
    localparam int IXW   = (INDEX_W > LIM_W) ? INDEX_W : LIM_W;
    localparam int PW    = 3 * CB;
    localparam int DW    = CB + 1;
    localparam int SQW   = 2 * DW;
    localparam int SUMW  = SQW + 2;
    localparam int RW    = (SUMW + 1) / 2;
    localparam int CMPW  = (RW > SEP_W) ? RW : SEP_W;

    // Configuration registers
    logic [COUNT_W-1:0] point_count_reg;
    logic [SEP_W-1:0]   max_sep_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            max_sep_reg     <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POINT_COUNT: point_count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_MAX_SEP:     max_sep_reg     <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Walk limit and query slot range check
    logic [LW2-1:0]   limit_w;
    logic [LIM_W-1:0] limit;
    logic             idx_ok;
    logic [AW-1:0]    in_addr;

    assign limit_w = (LW2'(point_count_reg) < LW2'(MAX_POINTS)) ?
                     LW2'(point_count_reg) : LW2'(MAX_POINTS);
    assign limit   = limit_w[LIM_W-1:0];
    assign idx_ok  = IXW'(index) < IXW'(MAX_POINTS);
    assign in_addr = AW'(index);

    // Point store, one write and one registered read per cycle
    logic [PW-1:0] mem [MAX_POINTS];
    logic [PW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [LIM_W-1:0] j_reg;

    assign rd_addr = cmd.q_start ? in_addr : j_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && idx_ok)
        begin
            mem[in_addr] <= {coord_x, coord_y, coord_z};
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Query context
    logic [AW-1:0] q_idx_reg;
    logic          q_oob_reg;
    logic [PW-1:0] qpt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_oob_reg <= 1'b0;
            j_reg     <= '0;
        end
        else if (cmd.q_start)
        begin
            q_oob_reg <= !idx_ok;
            j_reg     <= '0;
        end
        else if (cmd.walk_issue)
        begin
            j_reg <= j_reg + LIM_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_start)
        begin
            q_idx_reg <= in_addr;
        end
        if (cmd.q_latch)
        begin
            qpt_reg <= rd_data_reg;
        end
    end

    // Pipeline valid tags: read, abs diff, square, sum
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.walk_issue && (j_reg[AW-1:0] != q_idx_reg);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Per-axis absolute difference and square
    logic [CB-1:0]  qc [3];
    logic [CB-1:0]  rc [3];
    logic [DW-1:0]  dd [3];
    logic [DW-1:0]  ad_next [3];
    logic [DW-1:0]  ad_reg [3];
    logic [SQW-1:0] sq_next [3];
    logic [SQW-1:0] sq_reg [3];
    logic [SUMW-1:0] sum_next;
    logic [SUMW-1:0] sum_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qc[k]      = qpt_reg[PW-1-k*CB -: CB];
            rc[k]      = rd_data_reg[PW-1-k*CB -: CB];
            dd[k]      = {qc[k][CB-1], qc[k]} - {rc[k][CB-1], rc[k]};
            ad_next[k] = dd[k][CB] ? (~dd[k] + DW'(1)) : dd[k];
            sq_next[k] = ad_reg[k] * ad_reg[k];
        end
    end

    assign sum_next = SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            ad_reg[k] <= ad_next[k];
            sq_reg[k] <= sq_next[k];
        end
        sum_reg <= sum_next;
    end

    // Running minimum, strict less-than
    logic [SUMW-1:0] best_reg;
    logic            found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.q_start)
        begin
            found_reg <= 1'b0;
        end
        else if (v4_reg)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg && (!found_reg || (sum_reg < best_reg)))
        begin
            best_reg <= sum_reg;
        end
    end

    // Square root of the minimum
    logic          sqrt_busy;
    logic          sqrt_done;
    logic [RW-1:0] root;

    nnd_isqrt #(
        .IN_W (SUMW)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .value (best_reg),
        .busy  (sqrt_busy),
        .done  (sqrt_done),
        .root  (root)
    );

    // Result, capped at max_separation
    logic [SEP_W-1:0] result_reg;
    logic             root_lower;

    assign root_lower = found_reg && (CMPW'(root) < CMPW'(max_sep_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            result_reg <= root_lower ? SEP_W'(root) : max_sep_reg;
        end
    end

    assign min_distance    = result_reg;
    assign stat.q_oob      = q_oob_reg;
    assign stat.walk_done  = (j_reg == limit);
    assign stat.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign stat.found      = found_reg;
    assign stat.sqrt_done  = sqrt_done;

    // Checks
    `NND_ASSERT_IMPLIES(a_sqrt_after_drain, clk, rst_n, cmd.sqrt_start, stat.pipe_empty && found_reg)
    `NND_ASSERT_NEXT(a_result_capped, clk, rst_n, cmd.result_load, result_reg <= max_sep_reg)
    `NND_ASSERT_NEXT(a_best_held_in_sqrt, clk, rst_n, sqrt_busy, $stable(best_reg))

endmodule

FILE: hdl/nnd_ctrl.sv
// Controller state machine sequencing loads and queries.
`timescale 1ns / 1ps
`include "nearest_neighbor_distance_core_macros.svh"

module nnd_ctrl
    import nnd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      op,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  nnd_stat_t stat,
    output nnd_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QREAD,
        ST_WALK,
        ST_DRAIN,
        ST_SQRT,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;

    // Commands decoded from state
    always_comb
    begin
        cmd.load_we     = (state_reg == ST_IDLE) && in_valid && (op == OP_LOAD);
        cmd.q_start     = (state_reg == ST_IDLE) && in_valid && (op == OP_QUERY);
        cmd.q_latch     = (state_reg == ST_QREAD);
        cmd.walk_issue  = (state_reg == ST_WALK) && !stat.walk_done;
        cmd.sqrt_start  = (state_reg == ST_DRAIN) && stat.pipe_empty && stat.found;
        cmd.result_load = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.q_start)
                    begin
                        state_reg <= ST_QREAD;
                    end
                end
                ST_QREAD:
                begin
                    state_reg <= stat.q_oob ? ST_FINISH : ST_WALK;
                end
                ST_WALK:
                begin
                    if (stat.walk_done)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (stat.pipe_empty)
                    begin
                        state_reg <= stat.found ? ST_SQRT : ST_FINISH;
                    end
                end
                ST_SQRT:
                begin
                    if (stat.sqrt_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (cmd.result_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Checks
    `NND_ASSERT_IMPLIES(a_result_from_finish, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_FINISH)
    `NND_ASSERT_NEXT(a_walk_follows_read, clk, rst_n, cmd.q_latch && !stat.q_oob, state_reg == ST_WALK)
    `NND_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && !out_ready, out_valid_reg)

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the nearest neighbor distance core: directed table, then random.
`timescale 1ns / 1ps

module tb;
    import nnd_pkg::*;

    localparam int N_SLOTS        = 1024;
    localparam int COORD_W        = 16;
    localparam int RAND_ITEMS     = 570;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SQUEEZE_CYCLES = 3000;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 64;
    localparam int FILL_AFTER     = 300;
    localparam int SQUEEZE_AFTER  = 150;
    localparam logic [SEP_W-1:0] SEP_MAX = '1;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

    // One row of the directed table: a register write or an item
    typedef struct packed {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        logic                    op_v;
        logic [INDEX_W-1:0]      idx;
        logic [COORD_W-1:0]      x;
        logic [COORD_W-1:0]      y;
        logic [COORD_W-1:0]      z;
        logic                    typed;
        logic [SEP_W-1:0]        want;
    } plan_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      op;
    logic [INDEX_W-1:0]        index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      out_valid;
    logic                      out_ready;
    logic [SEP_W-1:0]          min_distance;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_wdata;

    // Shadow copy of the point store and registers
    logic signed [COORD_W-1:0] shadow_x [N_SLOTS];
    logic signed [COORD_W-1:0] shadow_y [N_SLOTS];
    logic signed [COORD_W-1:0] shadow_z [N_SLOTS];
    bit                        written  [N_SLOTS];
    int                        loaded_slots [$];
    logic [COUNT_W-1:0]        shadow_count;
    logic [SEP_W-1:0]          shadow_sep;

    logic [SEP_W-1:0] pending_dist [$];
    plan_row_t        directed_plan [$];

    int          errors;
    int          random_sent;
    int          idle_cycles;
    int          tx_calm;
    int          rx_calm;
    bit          counting;
    bit          store_full;
    bit          squeeze_req;
    bit          squeezed;
    logic [15:0] cluster;

    nearest_neighbor_distance_core #(
        .MAX_POINTS (N_SLOTS),
        .COORD_BITS (COORD_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .index        (index),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .min_distance (min_distance),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Floor square root, one result bit at a time
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] cand;
        int          b;
        r = '0;
        for (b = 20; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if (cand * cand <= v)
                r = cand;
        end
        return r;
    endfunction

    // Smallest distance from slot q to any other searched slot, capped
    function automatic logic [SEP_W-1:0] nearest_distance(input logic [INDEX_W-1:0] q);
        longint      dx;
        longint      dy;
        longint      dz;
        logic [63:0] d2;
        logic [63:0] best;
        logic [63:0] root;
        bit          found;
        int          lim;
        int          j;
        found = 1'b0;
        best  = '0;
        lim   = (shadow_count > N_SLOTS) ? N_SLOTS : int'(shadow_count);
        for (j = 0; j < lim; j++)
        begin
            if (j != int'(q))
            begin
                dx = longint'(shadow_x[j]) - longint'(shadow_x[q]);
                dy = longint'(shadow_y[j]) - longint'(shadow_y[q]);
                dz = longint'(shadow_z[j]) - longint'(shadow_z[q]);
                d2 = dx * dx + dy * dy + dz * dz;
                // strict less-than: a tie keeps the earlier value
                if (!found || d2 < best)
                begin
                    best  = d2;
                    found = 1'b1;
                end
            end
        end
        if (!found)
            return shadow_sep;
        root = floor_root(best);
        return (root < 64'(shadow_sep)) ? root[SEP_W-1:0] : shadow_sep;
    endfunction

    // Pause length: mostly none or short, a few long, with calm stretches
    function automatic int pick_pause(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Coordinate: extremes, full range, or near the phase cluster
    function automatic logic [15:0] pick_coord(input logic [15:0] center);
        int          r;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        w = $urandom;
        if (r < 12)
        begin
            case (w[1:0])
                2'd0:    return 16'h8000;
                2'd1:    return 16'h7fff;
                2'd2:    return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        if (r < 55)
            return w[15:0];
        return center + {9'd0, w[6:0]} - 16'd64;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (store_full && r < 4)
        begin
            case ($urandom_range(0, 3))
                0:       return CFG_DATA_W'(1024);
                1:       return CFG_DATA_W'(1025);
                2:       return CFG_DATA_W'(2047);
                default: return CFG_DATA_W'($urandom_range(1026, 2046));
            endcase
        end
        if (r < 12)
            return CFG_DATA_W'($urandom_range(0, 1));
        if (r < 75)
            return CFG_DATA_W'($urandom_range(2, 12));
        return CFG_DATA_W'($urandom_range(13, 48));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_sep();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return SEP_MAX;
        if (r < 55)
            return '0;
        if (r < 80)
            return CFG_DATA_W'($urandom_range(1, 400));
        return CFG_DATA_W'($urandom_range(0, 131071));
    endfunction

    // Every slot below lim has been loaded
    function automatic bit prefix_written(input int lim);
        int j;
        for (j = 0; j < lim; j++)
            if (!written[j])
                return 1'b0;
        return 1'b1;
    endfunction

    // Query slot: below the search limit, or any loaded slot
    function automatic logic [INDEX_W-1:0] pick_query_slot(input int lim);
        int t;
        if (lim > 0 && $urandom_range(0, 3) != 0)
            t = $urandom_range(0, lim - 1);
        else
            t = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
        return t[INDEX_W-1:0];
    endfunction

    // Offer one item, wait for it to be taken, then update the shadow state
    task automatic send_item(input logic op_v, input logic [INDEX_W-1:0] idx,
                             input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input bit typed,
                             input logic [SEP_W-1:0] want);
        int gap;
        gap = pick_pause(tx_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= op_v;
        index    <= idx;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op_v == OP_LOAD)
        begin
            shadow_x[idx] = x;
            shadow_y[idx] = y;
            shadow_z[idx] = z;
            if (!written[idx])
            begin
                written[idx] = 1'b1;
                loaded_slots = {loaded_slots, int'(idx)};
            end
        end
        else
            pending_dist = {pending_dist, (typed ? want : nearest_distance(idx))};
        if (counting)
            random_sent++;
    endtask

    task automatic send_query(input logic [INDEX_W-1:0] idx);
        logic [31:0] w;
        w = $urandom;
        send_item(OP_QUERY, idx, w[15:0], w[31:16], w[23:8], 1'b0, '0);
    endtask

    // Register write once the block has gone idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_dist.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (r == CFG_POINT_COUNT)
            shadow_count = v[COUNT_W-1:0];
        else
            shadow_sep = v[SEP_W-1:0];
        @(posedge clk);
    endtask

    task automatic plan_cfg(input logic [CFG_IDX_W-1:0] r, input logic [CFG_DATA_W-1:0] v);
        plan_row_t row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_idx = r;
        row.reg_val = v;
        directed_plan = {directed_plan, row};
    endtask

    task automatic plan_load(input logic [INDEX_W-1:0] idx, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.op_v = OP_LOAD;
        row.idx  = idx;
        row.x    = x;
        row.y    = y;
        row.z    = z;
        directed_plan = {directed_plan, row};
    endtask

    task automatic plan_query(input logic [INDEX_W-1:0] idx, input bit typed,
                              input logic [SEP_W-1:0] want);
        plan_row_t row;
        row       = '0;
        row.kind  = ROW_ITEM;
        row.op_v  = OP_QUERY;
        row.idx   = idx;
        row.typed = typed;
        row.want  = want;
        directed_plan = {directed_plan, row};
    endtask

    // Well-formed phase: set the count, load the searched slots, then query
    task automatic run_search_phase();
        logic [CFG_DATA_W-1:0] pc;
        logic [31:0]           w;
        int                    lim;
        int                    k;
        int                    nq;
        pc = pick_count();
        write_reg(CFG_POINT_COUNT, pc);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_MAX_SEP, pick_sep());
        lim = (pc > N_SLOTS) ? N_SLOTS : int'(pc);
        w = $urandom;
        cluster = w[15:0];
        for (k = 0; k < lim; k++)
            if (!written[k] || (lim <= 64 && $urandom_range(0, 2) == 0))
                send_item(OP_LOAD, k[INDEX_W-1:0], pick_coord(cluster), pick_coord(cluster),
                          pick_coord(cluster), 1'b0, '0);
        nq = $urandom_range(1, 6);
        // one long receiver hold while queries keep coming, enough to fill the block
        if (!squeezed && random_sent > SQUEEZE_AFTER)
        begin
            squeeze_req = 1'b1;
            squeezed    = 1'b1;
            nq          = $urandom_range(3, 6);
        end
        for (k = 0; k < nq; k++)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                w = $urandom;
                if (lim > 0 && w[31])
                    w[9:0] = 10'($urandom_range(0, lim - 1));
                send_item(OP_LOAD, w[9:0], pick_coord(cluster), pick_coord(cluster),
                          pick_coord(cluster), 1'b0, '0);
            end
            send_query(pick_query_slot(lim));
        end
    endtask

    // Noise phase: scattered loads anywhere, queries where legal
    task automatic run_noise_phase();
        logic [31:0] w;
        logic [31:0] c;
        int          n;
        int          k;
        int          lim;
        lim = (shadow_count > N_SLOTS) ? N_SLOTS : int'(shadow_count);
        n = $urandom_range(4, 16);
        for (k = 0; k < n; k++)
        begin
            w = $urandom;
            c = $urandom;
            if (w[31] && prefix_written(lim))
                send_query(pick_query_slot(0));
            else
                send_item(OP_LOAD, w[9:0], c[15:0], c[31:16], w[25:10], 1'b0, '0);
        end
    endtask

    // Load every slot once, then search the whole store and beyond it
    task automatic run_fill_phase();
        logic [31:0] w;
        int          k;
        counting = 1'b0;
        for (k = 0; k < N_SLOTS; k++)
        begin
            if (!written[k])
            begin
                w = $urandom;
                send_item(OP_LOAD, k[INDEX_W-1:0], w[15:0], w[31:16], pick_coord(w[15:0]),
                          1'b0, '0);
            end
        end
        counting   = 1'b1;
        store_full = 1'b1;
        write_reg(CFG_POINT_COUNT, CFG_DATA_W'(1024));
        send_query(INDEX_W'($urandom_range(0, 1023)));
        write_reg(CFG_POINT_COUNT, CFG_DATA_W'(2047));
        write_reg(CFG_MAX_SEP, pick_sep());
        send_query(INDEX_W'($urandom_range(0, 1023)));
        write_reg(CFG_POINT_COUNT, CFG_DATA_W'(1025));
        send_query(INDEX_W'($urandom_range(0, 1023)));
    endtask

    // Result checker
    always @(posedge clk)
    begin : result_check
        logic [SEP_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_dist.size() == 0)
            begin
                $error("min_distance: unexpected result, expected none, actual %0d",
                       min_distance);
                errors++;
            end
            else
            begin
                want = pending_dist.pop_front();
                if (min_distance !== want)
                begin
                    $error("min_distance mismatch: expected %0d, actual %0d",
                           want, min_distance);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with no progress
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver ready pattern, with one long hold on request
    initial
    begin : rx_drive
        int stall;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                squeeze_req = 1'b0;
                out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                stall = pick_pause(rx_calm);
                if (stall == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    repeat (stall - 1) @(negedge clk);
                end
            end
        end
    end

    // Main sequence
    initial
    begin : main_seq
        int i;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_LOAD;
        index        = '0;
        coord_x      = '0;
        coord_y      = '0;
        coord_z      = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_POINT_COUNT;
        cfg_wdata    = '0;
        shadow_count = '0;
        shadow_sep   = SEP_MAX;
        errors       = 0;
        random_sent  = 0;
        idle_cycles  = 0;
        tx_calm      = 0;
        rx_calm      = 0;
        counting     = 1'b0;
        store_full   = 1'b0;
        squeeze_req  = 1'b0;
        squeezed     = 1'b0;
        cluster      = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no neighbor: empty count, then only the query slot itself
        plan_load(10'd0, 16'h0000, 16'h0000, 16'h0000);
        plan_query(10'd0, 1'b1, SEP_MAX);
        plan_cfg(CFG_POINT_COUNT, 17'd1);
        plan_query(10'd0, 1'b1, SEP_MAX);
        // coordinate extremes
        plan_load(10'd1, 16'h7fff, 16'h7fff, 16'h7fff);
        plan_load(10'd2, 16'h8000, 16'h8000, 16'h8000);
        plan_cfg(CFG_POINT_COUNT, 17'd3);
        plan_query(10'd1, 1'b0, '0);
        plan_query(10'd2, 1'b0, '0);
        // query slot at or above the count
        plan_cfg(CFG_POINT_COUNT, 17'd2);
        plan_query(10'd2, 1'b0, '0);
        // duplicate point gives zero
        plan_load(10'd3, 16'h0000, 16'h0000, 16'h0000);
        plan_cfg(CFG_POINT_COUNT, 17'd4);
        plan_query(10'd3, 1'b1, '0);
        // cap at zero
        plan_cfg(CFG_MAX_SEP, 17'd0);
        plan_query(10'd1, 1'b1, '0);
        // tied neighbors at 100; cap equal, below and above
        plan_load(10'd1, 16'd100, 16'h0000, 16'h0000);
        plan_cfg(CFG_MAX_SEP, 17'd100);
        plan_query(10'd1, 1'b1, 17'd100);
        plan_cfg(CFG_MAX_SEP, 17'd99);
        plan_query(10'd1, 1'b1, 17'd99);
        plan_cfg(CFG_MAX_SEP, SEP_MAX);
        plan_query(10'd1, 1'b1, 17'd100);
        // top slot, outside the searched range
        plan_load(10'd1023, 16'h7fff, 16'h8000, 16'h7fff);
        plan_query(10'd1023, 1'b0, '0);

        for (i = 0; i < directed_plan.size(); i++)
        begin
            if (directed_plan[i].kind == ROW_CFG)
                write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
            else
                send_item(directed_plan[i].op_v, directed_plan[i].idx, directed_plan[i].x,
                          directed_plan[i].y, directed_plan[i].z, directed_plan[i].typed,
                          directed_plan[i].want);
        end

        // random part
        counting = 1'b1;
        while (random_sent < RAND_ITEMS)
        begin
            if (!store_full && random_sent >= FILL_AFTER)
                run_fill_phase();
            else if ($urandom_range(0, 9) < 7)
                run_search_phase();
            else
                run_noise_phase();
        end

        // drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
